/* rtl/trq_pkg.sv */
`timescale 1ns / 1ps

package trq_pkg;

  // Width of one presentation timestamp.
  localparam int unsigned TsW = 64;

  // Width of the reported queue length.
  localparam int unsigned CountOutW = 9;

  // Operation that every cell of the row performs together.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  // Control word broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e              op;
    logic signed [TsW-1:0] ts;
  } cell_ctrl_t;

endpackage

/* rtl/trq_in_if.sv */
`timescale 1ns / 1ps

interface trq_in_if;

  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic                           packet_present;
  logic signed [trq_pkg::TsW-1:0] timestamp;
  logic                           picture_ready;

  modport source (
    output valid, mode, packet_present, timestamp, picture_ready,
    input  ready
  );

  modport sink (
    input  valid, mode, packet_present, timestamp, picture_ready,
    output ready
  );

endinterface

/* rtl/trq_out_if.sv */
`timescale 1ns / 1ps

interface trq_out_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 picture_out;
  logic                                 timestamp_valid;
  logic signed [trq_pkg::TsW-1:0]       out_timestamp;
  logic        [trq_pkg::CountOutW-1:0] queue_count;

  modport source (
    output valid, picture_out, timestamp_valid, out_timestamp, queue_count,
    input  ready
  );

  modport sink (
    input  valid, picture_out, timestamp_valid, out_timestamp, queue_count,
    output ready
  );

endinterface

/* rtl/trq_cell.sv */
`timescale 1ns / 1ps

module trq_cell (
  input  logic                           clk_i,
  input  trq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           occupied_i,
  input  logic                           prev_less_i,
  input  logic signed [trq_pkg::TsW-1:0] prev_entry_i,
  input  logic signed [trq_pkg::TsW-1:0] next_entry_i,
  output logic                           less_o,
  output logic signed [trq_pkg::TsW-1:0] entry_o
);
  import trq_pkg::*;

  logic signed [TsW-1:0] entry_q;
  logic signed [TsW-1:0] entry_d;

  // A held entry smaller than the new timestamp stays in place on insert.
  assign less_o = occupied_i && (entry_q < ctrl_i.ts);

  // Keep, take the new timestamp, or take a neighbor's entry.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (less_o) begin
          entry_d = entry_q;
        end else if (prev_less_i) begin
          entry_d = ctrl_i.ts;
        end else begin
          entry_d = prev_entry_i;
        end
      end
      OP_POP:  entry_d = next_entry_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/trq_chain.sv */
`timescale 1ns / 1ps

module trq_chain #(
  parameter int unsigned Depth = 256,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                           clk_i,
  input  trq_pkg::cell_ctrl_t            ctrl_i,
  input  logic [CntW-1:0]                count_i,
  output logic signed [trq_pkg::TsW-1:0] head_o
);
  import trq_pkg::*;

  logic                  less   [Depth];
  logic signed [TsW-1:0] entry  [Depth];

  // Row of cells; each talks only to its adjacent cells.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                  occupied;
    logic                  prev_less;
    logic signed [TsW-1:0] prev_entry;
    logic signed [TsW-1:0] next_entry;

    assign occupied = CntW'(i) < count_i;

    if (i == 0) begin : g_first
      assign prev_less  = 1'b1;
      assign prev_entry = ctrl_i.ts;
    end else begin : g_mid
      assign prev_less  = less[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    trq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .occupied_i   (occupied),
      .prev_less_i  (prev_less),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .less_o       (less[i]),
      .entry_o      (entry[i])
    );
  end

  // The smallest held timestamp always sits in the first cell.
  assign head_o = entry[0];

endmodule

/* rtl/timestamp_reorder_queue.sv */
`timescale 1ns / 1ps

// Sorted presentation-timestamp queue built as a row of QUEUE_DEPTH cells.
// Each item either flushes the queue or inserts an optional timestamp in
// ascending signed order (ahead of equal entries; dropped when full) and
// then, if a picture is ready and the length has reached its high-water
// mark, releases the picture with the smallest timestamp. Each item steps
// through accept, one insert shift of the cell row, one pop shift of the
// row, and the load of the output register, which waits for a free slot,
// before the next item is accepted. The output register lets the next
// item be accepted while a result waits. No clearing pass is needed after
// reset; only cells below the current length are ever read.
module timestamp_reorder_queue #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  trq_in_if.sink           in_i,
  trq_out_if.source        out_o
);
  import trq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INSERT = 4'b0010,
    S_POP    = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] hw_q, hw_d;

  // Captured item.
  logic                  mode_q;
  logic                  present_q;
  logic signed [TsW-1:0] ts_q;
  logic                  pic_ready_q;

  // Computed result, waiting for the output register.
  logic                  res_pic_q, res_pic_d;
  logic                  res_valid_q, res_valid_d;
  logic signed [TsW-1:0] res_ts_q, res_ts_d;

  // Output register.
  logic                  out_valid_q;
  logic                  out_pic_q;
  logic                  out_tsv_q;
  logic signed [TsW-1:0] out_ts_q;
  logic [CntW+CountOutW-1:0] count_ext;
  logic [CountOutW-1:0]  out_cnt_q;

  logic                  accept;
  logic                  out_free;
  logic                  release_pic;
  logic                  do_insert;
  logic signed [TsW-1:0] head;
  cell_ctrl_t            ctrl;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign do_insert   = !mode_q && present_q && (count_q != CntW'(QUEUE_DEPTH));
  assign release_pic = !mode_q && pic_ready_q && (count_q >= hw_q);

  // Sequencer and queue bookkeeping.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hw_d        = hw_q;
    res_pic_d   = res_pic_q;
    res_valid_d = res_valid_q;
    res_ts_d    = res_ts_q;
    ctrl.op     = OP_HOLD;
    ctrl.ts     = ts_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        if (mode_q) begin
          count_d = '0;
        end else if (do_insert) begin
          ctrl.op = OP_INSERT;
          count_d = count_q + CntW'(1);
          if (count_d > hw_q) begin
            hw_d = count_d;
          end
        end
        state_d = S_POP;
      end
      S_POP: begin
        res_pic_d   = release_pic;
        res_valid_d = 1'b0;
        res_ts_d    = '0;
        if (release_pic && (count_q != '0)) begin
          ctrl.op     = OP_POP;
          res_valid_d = 1'b1;
          res_ts_d    = head;
          count_d     = count_q - CntW'(1);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      hw_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hw_q    <= hw_d;
    end
  end

  // Item capture and result staging.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= in_i.mode;
      present_q   <= in_i.packet_present;
      ts_q        <= in_i.timestamp;
      pic_ready_q <= in_i.picture_ready;
    end
    res_pic_q   <= res_pic_d;
    res_valid_q <= res_valid_d;
    res_ts_q    <= res_ts_d;
  end

  // Output register; it is loaded when the result is ready and the slot is free.
  assign count_ext = {{CountOutW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && out_free) begin
      out_pic_q <= res_pic_q;
      out_tsv_q <= res_valid_q;
      out_ts_q  <= res_ts_q;
      out_cnt_q <= count_ext[CountOutW-1:0];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.picture_out     = out_pic_q;
  assign out_o.timestamp_valid = out_tsv_q;
  assign out_o.out_timestamp   = out_ts_q;
  assign out_o.queue_count     = out_cnt_q;

  // Row of sorted cells.
  trq_chain #(
    .Depth (QUEUE_DEPTH),
    .CntW  (CntW)
  ) u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .count_i (count_q),
    .head_o  (head)
  );

  // The length never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue length exceeds depth");

  // The high-water mark is never below the current length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hw_q)
    else $error("high-water mark below queue length");

  // A pop with a held entry shortens the queue by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) && release_pic && (count_q != '0)
      |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not shorten the queue");

  // An accepted item moves the block to insert and drops ready, so no second item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_INSERT) && !in_i.ready)
    else $error("item accepted while another is in flight");

endmodule

/* dv/trq_tb_pkg.sv */
`timescale 1ns / 1ps

package trq_tb_pkg;

  // Values of the mode field of a decode call.
  localparam logic ModeDecode = 1'b0;
  localparam logic ModeFlush  = 1'b1;

endpackage

/* dv/trq_release_checker.sv */
`timescale 1ns / 1ps

// Watches the call and release channels, keeps its own sorted timestamp
// queue and compares every released item with the release it predicts.
module trq_release_checker #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  trq_in_if    call_i,
  trq_out_if   release_i,
  output int   fail_count_o,
  output int   releases_due_o
);

  import trq_pkg::*;
  import trq_tb_pkg::*;

  // One predicted release, laid out like the output channel payload.
  typedef struct packed {
    logic                   picture_out;
    logic                   timestamp_valid;
    logic signed [TsW-1:0]  out_timestamp;
    logic [CountOutW-1:0]   queue_count;
  } release_t;

  logic signed [TsW-1:0] held_ts_q[$];
  int                    high_water;
  release_t              release_due_q[$];
  int                    fail_cnt;

  // Applies one call to the timestamp queue and returns the release it causes.
  function automatic release_t apply_call(input logic call_mode, input logic present,
                                          input logic signed [TsW-1:0] ts,
                                          input logic picture_ready);
    release_t rel;
    int       pos;
    rel = '0;
    if (call_mode == ModeFlush) begin
      held_ts_q.delete();
    end else begin
      // A new timestamp goes ahead of equal entries; a full queue drops it.
      if (present && held_ts_q.size() < QUEUE_DEPTH) begin
        pos = 0;
        while (pos < held_ts_q.size() && held_ts_q[pos] < ts) pos++;
        held_ts_q.insert(pos, ts);
        if (held_ts_q.size() > high_water) high_water = held_ts_q.size();
      end
      // Release only once the length is back at its high-water mark.
      if (picture_ready && held_ts_q.size() >= high_water) begin
        rel.picture_out = 1'b1;
        if (held_ts_q.size() > 0) begin
          rel.timestamp_valid = 1'b1;
          rel.out_timestamp   = held_ts_q.pop_front();
        end
      end
    end
    rel.queue_count = CountOutW'(held_ts_q.size());
    return rel;
  endfunction

  // Compares one field and reports a difference.
  task automatic check_field(input string name, input logic [TsW-1:0] due,
                             input logic [TsW-1:0] seen);
    if (due !== seen) begin
      fail_cnt++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, due, seen);
    end
  endtask

  // Compare released items first, then record the release of a new call.
  always @(posedge clk_i or negedge rst_ni) begin
    release_t due;
    if (!rst_ni) begin
      held_ts_q.delete();
      release_due_q.delete();
      high_water = 0;
      fail_cnt = 0;
      fail_count_o <= 0;
      releases_due_o <= 0;
    end else begin
      if (release_i.valid && release_i.ready) begin
        if (release_due_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected release: expected none, actual ts %0h count %0d",
                   $time, release_i.out_timestamp, release_i.queue_count);
        end else begin
          due = release_due_q.pop_front();
          check_field("picture_out", due.picture_out, release_i.picture_out);
          check_field("timestamp_valid", due.timestamp_valid, release_i.timestamp_valid);
          check_field("out_timestamp", due.out_timestamp, release_i.out_timestamp);
          check_field("queue_count", due.queue_count, release_i.queue_count);
        end
      end
      if (call_i.valid && call_i.ready) begin
        release_due_q.push_back(apply_call(call_i.mode, call_i.packet_present,
                                           call_i.timestamp, call_i.picture_ready));
      end
      fail_count_o <= fail_cnt;
      releases_due_o <= release_due_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Drives decode calls into the reorder queue and takes its releases under
// several idling mixes; the checker beside the block does the comparing.
module tb_top;

  import trq_pkg::*;
  import trq_tb_pkg::*;

  localparam int unsigned QueueDepth = 256;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 600;
  localparam logic signed [TsW-1:0] TsMax = {1'b0, {(TsW-1){1'b1}}};
  localparam logic signed [TsW-1:0] TsMin = {1'b1, {(TsW-1){1'b0}}};

  logic    clk_i;
  logic    rst_ni;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_req = 0;
  int      fail_count;
  int      releases_due;
  longint  cycle_cnt = 0;

  trq_in_if  call_if ();
  trq_out_if release_if ();

  timestamp_reorder_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_i (call_if),
    .out_o(release_if)
  );

  trq_release_checker #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .call_i        (call_if),
    .release_i     (release_if),
    .fail_count_o  (fail_count),
    .releases_due_o(releases_due)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Ends a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timestamp_reorder_queue verification failed");
      $finish;
    end
  end

  // Release side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_len;
    release_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req > 0) begin
        hold_len = hold_off_req;
        hold_off_req = 0;
        release_if.ready <= 1'b0;
        for (int k = 0; k < hold_len; k++) @(posedge clk_i);
      end
      release_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Mix of extremes, small values that collide, and fully random patterns.
  function automatic logic signed [TsW-1:0] pick_timestamp();
    int small_val;
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(3))
          0: return TsMax;
          1: return TsMin;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: begin
        small_val = int'($urandom_range(16)) - 8;
        return TsW'(small_val);
      end
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offers one call after an optional idle gap and waits until it is taken.
  task automatic send_call(input logic call_mode, input logic present,
                           input logic signed [TsW-1:0] ts, input logic picture_ready);
    if ($urandom_range(99) < send_idle_pct) begin
      call_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    call_if.valid          <= 1'b1;
    call_if.mode           <= call_mode;
    call_if.packet_present <= present;
    call_if.timestamp      <= ts;
    call_if.picture_ready  <= picture_ready;
    do @(posedge clk_i); while (!call_if.ready);
  endtask

  // Mostly decode calls with a packet; occasional flushes.
  task automatic send_random_call(input int ready_pct);
    logic call_mode;
    logic present;
    logic picture_ready;
    call_mode     = ($urandom_range(99) < 3) ? ModeFlush : ModeDecode;
    present       = ($urandom_range(99) < 85);
    picture_ready = ($urandom_range(99) < ready_pct);
    send_call(call_mode, present, pick_timestamp(), picture_ready);
  endtask

  // Stops offering and waits until every predicted release has come out.
  task automatic drain_releases();
    call_if.valid <= 1'b0;
    @(posedge clk_i);
    while (releases_due != 0) @(posedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni                 <= 1'b0;
    call_if.valid          <= 1'b0;
    call_if.mode           <= ModeDecode;
    call_if.packet_present <= 1'b0;
    call_if.timestamp      <= '0;
    call_if.picture_ready  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed calls: empty release, extremes, equal values, flushes, holds.
    send_call(ModeDecode, 1'b0, '0, 1'b1);
    send_call(ModeDecode, 1'b0, TsMin, 1'b0);
    send_call(ModeDecode, 1'b1, TsMax, 1'b0);
    send_call(ModeDecode, 1'b1, TsMin, 1'b1);
    send_call(ModeDecode, 1'b1, '0, 1'b0);
    send_call(ModeDecode, 1'b1, '1, 1'b1);
    send_call(ModeDecode, 1'b1, 64'sd5, 1'b0);
    send_call(ModeDecode, 1'b1, 64'sd5, 1'b0);
    send_call(ModeDecode, 1'b1, {32{2'b01}}, 1'b0);
    send_call(ModeDecode, 1'b1, {32{2'b10}}, 1'b1);
    send_call(ModeDecode, 1'b0, '0, 1'b1);
    send_call(ModeFlush, 1'b1, TsMax, 1'b1);
    send_call(ModeDecode, 1'b1, TsMin, 1'b1);
    send_call(ModeFlush, 1'b0, '0, 1'b0);
    send_call(ModeDecode, 1'b0, '1, 1'b1);
    send_call(ModeDecode, 1'b1, TsMax, 1'b1);
    send_call(ModeDecode, 1'b1, TsMax, 1'b0);
    drain_releases();

    // Random calls under each idling mix; the first phase also holds off
    // the release side long enough for the block to stop taking calls.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_off_req   = HoldCycles;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      repeat (60) send_random_call(70);
      drain_releases();
    end

    // Fill the queue to the top, then keep offering so that packets drop.
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    repeat (QueueDepth + 10) send_call(ModeDecode, 1'b1, pick_timestamp(), 1'b0);
    repeat (20) send_random_call(50);
    send_call(ModeFlush, 1'b1, pick_timestamp(), 1'b1);
    send_call(ModeDecode, 1'b0, pick_timestamp(), 1'b1);
    send_call(ModeDecode, 1'b1, pick_timestamp(), 1'b1);
    drain_releases();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && releases_due == 0) begin
      $display("timestamp_reorder_queue verification clean");
    end else begin
      $display("timestamp_reorder_queue verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/trq_pkg.sv
rtl/trq_in_if.sv
rtl/trq_out_if.sv
rtl/trq_cell.sv
rtl/trq_chain.sv
rtl/timestamp_reorder_queue.sv
dv/trq_tb_pkg.sv
dv/trq_release_checker.sv
dv/tb_top.sv
